>>> rtl/triangle_tangent_accumulator_core_assert.svh
// Assertion helpers shared by the checker of the tangent accumulator core.
// Both macros expect signals named clk and rst_n in the scope where they are used.
`ifndef TRIANGLE_TANGENT_ACCUMULATOR_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_ACCUMULATOR_CORE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define TTA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tangent accumulator check failed");

// The condition must hold in the cycle after the trigger.
`define TTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tangent accumulator check failed");

`endif

>>> rtl/tta_pkg.sv
package tta_pkg;

  localparam int IDX_W  = 12;
  localparam int POS_W  = 24;
  localparam int TEX_W  = 16;
  localparam int UNIT_W = 16;
  localparam int EDGE_W = 25;
  localparam int UVD_W  = 17;
  localparam int PROD_W = 42;
  localparam int COMP_W = 44;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LOAD = 2'd0;
  localparam mode_t MODE_TRI  = 2'd1;
  localparam mode_t MODE_READ = 2'd2;
  localparam mode_t MODE_RSVD = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [EDGE_W-1:0] dlt_t;
  typedef logic signed [UVD_W-1:0] uvd_t;
  typedef logic [3:0] msel_t;

  localparam int    MUL_STEPS = 14;
  localparam msel_t MUL_LAST  = msel_t'(MUL_STEPS - 1);

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [TEX_W-1:0] u;
    logic signed [TEX_W-1:0] v;
  } vertex_t;

  typedef struct packed {
    idx_t    i0;
    idx_t    i1;
    idx_t    i2;
    vertex_t vtx;
  } in_item_t;

  typedef struct packed {
    idx_t  vertex_index;
    unit_t tx;
    unit_t ty;
    unit_t tz;
    unit_t bx;
    unit_t by;
    unit_t bz;
  } out_item_t;

  typedef enum logic [1:0] {
    NSEL_TRI_T,
    NSEL_TRI_B,
    NSEL_ACC_T,
    NSEL_ACC_B
  } nsel_t;

  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic       vert_rd;
    logic       acc_rd;
    logic       acc_wr;
    logic [1:0] corner;
    logic       mul_go;
    msel_t      mul_sel;
    logic       fix_sign;
    logic       norm_start;
    nsel_t      norm_sel;
    logic       store_t;
    logic       store_b;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic tri_ok;
    logic det_zero;
    logic norm_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/tta_if.sv
interface tta_in_if;
  logic                       valid;
  logic                       ready;
  tta_pkg::mode_t             mode;
  tta_pkg::idx_t              first_index;
  tta_pkg::idx_t              second_index;
  tta_pkg::idx_t              third_index;
  logic signed [23:0]         pos_x;
  logic signed [23:0]         pos_y;
  logic signed [23:0]         pos_z;
  logic signed [15:0]         tex_u;
  logic signed [15:0]         tex_v;

  modport source (output valid, mode, first_index, second_index, third_index,
                  pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink (input valid, mode, first_index, second_index, third_index,
                pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tta_out_if;
  logic               valid;
  logic               ready;
  tta_pkg::idx_t      vertex_index;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic signed [15:0] bitangent_x;
  logic signed [15:0] bitangent_y;
  logic signed [15:0] bitangent_z;

  modport source (output valid, vertex_index, tangent_x, tangent_y, tangent_z,
                  bitangent_x, bitangent_y, bitangent_z, input ready);
  modport sink (input valid, vertex_index, tangent_x, tangent_y, tangent_z,
                bitangent_x, bitangent_y, bitangent_z, output ready);
endinterface

>>> rtl/tta_norm.sv
// Iterative normalizer of a three component vector to Q1.14.
module tta_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  tta_pkg::comp_t comp [3],
  output tta_pkg::unit_t res [3],
  output logic           done
);

  localparam int CW     = tta_pkg::COMP_W;
  localparam int MW     = 24;
  localparam int SUM_W  = 50;
  localparam int LEN_W  = 25;
  localparam int QS     = 14;
  localparam int DIV_W  = LEN_W + QS;
  localparam int QW     = QS + 1;
  localparam logic [SUM_W-1:0] SQRT_TOP = SUM_W'(1) << (SUM_W - 2);

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DINIT, N_DIV} nstate_t;

  nstate_t              state_r;
  logic [CW-1:0]        mag_r [3];
  logic                 neg_r [3];
  logic [3:0]           cnt_r;
  logic [1:0]           k_r;
  logic [2*MW-1:0]      prod_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     root_r;
  logic [SUM_W-1:0]     bit_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     dvs_r;
  logic [QW-2:0]        quo_r;
  tta_pkg::unit_t       res_r [3];
  logic                 done_r;

  logic                 over;
  logic [SUM_W:0]       trial;
  logic                 sq_ge;
  logic [LEN_W-1:0]     len;
  logic                 div_ge;
  logic [QW-1:0]        quo_nxt;
  tta_pkg::unit_t       unit_nxt;
  logic [MW-1:0]        sq_in;

  assign over  = (|mag_r[0][CW-1:MW]) | (|mag_r[1][CW-1:MW]) | (|mag_r[2][CW-1:MW]);
  assign trial = {1'b0, root_r} + {1'b0, bit_r};
  assign sq_ge = {1'b0, sum_r} >= trial;
  assign len   = root_r[LEN_W-1:0];
  assign div_ge = rem_r >= dvs_r;
  assign quo_nxt = {quo_r, div_ge};
  assign sq_in = mag_r[0][MW-1:0];

  always_comb begin
    if (len == '0) begin
      unit_nxt = '0;
    end else if (neg_r[0]) begin
      unit_nxt = -tta_pkg::UNIT_W'({1'b0, quo_nxt});
    end else begin
      unit_nxt = tta_pkg::UNIT_W'({1'b0, quo_nxt});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg_r[i] <= comp[i][CW-1];
              mag_r[i] <= comp[i][CW-1] ? CW'(-comp[i]) : CW'(comp[i]);
            end
            state_r <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // Shift all magnitudes together until the largest fits in 24 bits.
          if (over) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i] <= mag_r[i] >> 1;
            end
          end else begin
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          prod_r <= {{MW{1'b0}}, sq_in} * {{MW{1'b0}}, sq_in};
          if (cnt_r != 4'd0) begin
            sum_r <= sum_r + SUM_W'(prod_r);
          end
          if (cnt_r == 4'd3) begin
            root_r  <= '0;
            bit_r   <= SQRT_TOP;
            state_r <= N_SQRT;
          end else begin
            mag_r[0] <= mag_r[1];
            mag_r[1] <= mag_r[2];
            mag_r[2] <= mag_r[0];
            neg_r[0] <= neg_r[1];
            neg_r[1] <= neg_r[2];
            neg_r[2] <= neg_r[0];
            cnt_r    <= cnt_r + 4'd1;
          end
        end
        N_SQRT: begin
          if (sq_ge) begin
            sum_r  <= sum_r - trial[SUM_W-1:0];
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            k_r     <= '0;
            state_r <= N_DINIT;
          end
        end
        N_DINIT: begin
          rem_r   <= {1'b0, mag_r[0][MW-1:0], {QS{1'b0}}} + DIV_W'(len >> 1);
          dvs_r   <= {len, {QS{1'b0}}};
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          if (div_ge) begin
            rem_r <= rem_r - dvs_r;
          end
          quo_r <= quo_nxt[QW-2:0];
          dvs_r <= dvs_r >> 1;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(QW - 1)) begin
            res_r[0] <= res_r[1];
            res_r[1] <= res_r[2];
            res_r[2] <= unit_nxt;
            mag_r[0] <= mag_r[1];
            mag_r[1] <= mag_r[2];
            mag_r[2] <= mag_r[0];
            neg_r[0] <= neg_r[1];
            neg_r[1] <= neg_r[2];
            neg_r[2] <= neg_r[0];
            if (k_r == 2'd2) begin
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= N_DINIT;
            end
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

>>> rtl/tta_ctrl.sv
// Sequencer for loads, triangles and readouts.
module tta_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  tta_pkg::mode_t  in_mode,
  input  tta_pkg::sts_t   sts,
  output logic            in_ready,
  output tta_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_TRI_RD, S_TRI_DLT, S_TRI_MUL, S_TRI_MWAIT, S_TRI_SIGN,
    S_NORM_T, S_WAIT_T, S_NORM_B, S_WAIT_B, S_ACC_RD, S_ACC_WR, S_RO_RD, S_OUT
  } state_t;

  state_t     state_r;
  logic [3:0] cnt_r;
  logic       ro_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ro_r    <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          ro_r  <= (in_mode == tta_pkg::MODE_READ);
          if (in_valid) begin
            case (in_mode)
              tta_pkg::MODE_LOAD: state_r <= S_LOAD;
              tta_pkg::MODE_TRI:  state_r <= S_TRI_RD;
              tta_pkg::MODE_READ: state_r <= S_RO_RD;
              default:            state_r <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state_r <= S_IDLE;
        S_TRI_RD: begin
          if (!sts.tri_ok) begin
            state_r <= S_IDLE;
          end else if (cnt_r == 4'd2) begin
            state_r <= S_TRI_DLT;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_TRI_DLT: begin
          cnt_r   <= '0;
          state_r <= S_TRI_MUL;
        end
        S_TRI_MUL: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == tta_pkg::MUL_LAST) begin
            state_r <= S_TRI_MWAIT;
          end
        end
        S_TRI_MWAIT: state_r <= S_TRI_SIGN;
        S_TRI_SIGN: state_r <= sts.det_zero ? S_IDLE : S_NORM_T;
        S_NORM_T: state_r <= S_WAIT_T;
        S_WAIT_T: begin
          if (sts.norm_done) begin
            state_r <= S_NORM_B;
          end
        end
        S_NORM_B: state_r <= S_WAIT_B;
        S_WAIT_B: begin
          if (sts.norm_done) begin
            cnt_r   <= '0;
            state_r <= ro_r ? S_OUT : S_ACC_RD;
          end
        end
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          if (cnt_r == 4'd2) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + 4'd1;
            state_r <= S_ACC_RD;
          end
        end
        S_RO_RD: state_r <= S_NORM_T;
        S_OUT: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state_r == S_IDLE) && in_valid;
    cmd.load_wr    = (state_r == S_LOAD);
    cmd.vert_rd    = (state_r == S_TRI_RD) && sts.tri_ok;
    cmd.acc_rd     = (state_r == S_ACC_RD) || (state_r == S_RO_RD);
    cmd.acc_wr     = (state_r == S_ACC_WR);
    cmd.mul_go     = (state_r == S_TRI_MUL);
    cmd.mul_sel    = cnt_r;
    cmd.fix_sign   = (state_r == S_TRI_SIGN) && !sts.det_zero;
    cmd.norm_start = (state_r == S_NORM_T) || (state_r == S_NORM_B);
    cmd.store_t    = (state_r == S_WAIT_T) && sts.norm_done;
    cmd.store_b    = (state_r == S_WAIT_B) && sts.norm_done;
    cmd.out_load   = (state_r == S_OUT) && sts.out_free;
    if ((state_r == S_TRI_RD) || (state_r == S_ACC_RD) || (state_r == S_ACC_WR)) begin
      cmd.corner = cnt_r[1:0];
    end
    if (state_r == S_NORM_B) begin
      cmd.norm_sel = ro_r ? tta_pkg::NSEL_ACC_B : tta_pkg::NSEL_TRI_B;
    end else begin
      cmd.norm_sel = ro_r ? tta_pkg::NSEL_ACC_T : tta_pkg::NSEL_TRI_T;
    end
  end

endmodule

>>> rtl/tta_dp.sv
// Vertex and accumulator stores, edge arithmetic, normalizer and result register.
module tta_dp #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int ACCUM_WIDTH  = 21
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tta_pkg::cmd_t      cmd,
  input  tta_pkg::in_item_t  in_item,
  input  logic               out_ready,
  output tta_pkg::sts_t      sts,
  output logic               out_valid,
  output tta_pkg::out_item_t out_item
);

  localparam int AW     = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int IW     = tta_pkg::IDX_W;
  localparam int ROW_W  = 6 * ACCUM_WIDTH;
  localparam int CW     = tta_pkg::COMP_W;
  localparam int EW     = tta_pkg::EDGE_W;
  localparam int UW     = tta_pkg::UVD_W;
  localparam int PW     = tta_pkg::PROD_W;
  localparam int SW     = ACCUM_WIDTH + 1;
  localparam logic [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

  tta_pkg::idx_t    i0_r, i1_r, i2_r;
  tta_pkg::vertex_t vtx_r;
  tta_pkg::vertex_t pa_r, pb_r, pc_r;
  tta_pkg::vertex_t vmem [VERTEX_DEPTH];
  logic [ROW_W-1:0] amem [VERTEX_DEPTH];
  logic [ROW_W-1:0] acc_q_r;

  tta_pkg::uvd_t du1_r, dv1_r, du2_r, dv2_r;
  tta_pkg::dlt_t e1_r [3];
  tta_pkg::dlt_t e2_r [3];

  tta_pkg::uvd_t        opa;
  tta_pkg::dlt_t        opb;
  logic signed [PW-1:0] prod_r;
  logic                 mv_r;
  tta_pkg::msel_t       msel_d_r;
  tta_pkg::comp_t       res_r [7];
  logic [2:0]           ridx;

  tta_pkg::idx_t        idx_sel;
  logic [AW+IW-1:0]     idx_ext;
  logic [AW-1:0]        addr;
  logic                 i0_ok, tri_ok;

  tta_pkg::comp_t       nin [3];
  tta_pkg::unit_t       nres [3];
  logic                 ndone;
  tta_pkg::unit_t       tn_r [3];
  tta_pkg::unit_t       bn_r [3];

  logic signed [SW-1:0] sat_sum [6];
  logic [ROW_W-1:0]     sat_row;
  logic [ROW_W-1:0]     amem_wd;
  logic                 amem_we;

  logic                 out_valid_r;
  tta_pkg::out_item_t   out_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      i0_r  <= in_item.i0;
      i1_r  <= in_item.i1;
      i2_r  <= in_item.i2;
      vtx_r <= in_item.vtx;
    end
  end

  always_comb begin
    case (cmd.corner)
      2'd0:    idx_sel = i0_r;
      2'd1:    idx_sel = i1_r;
      default: idx_sel = i2_r;
    endcase
  end

  assign idx_ext = {{AW{1'b0}}, idx_sel};
  assign addr    = idx_ext[AW-1:0];
  assign i0_ok   = 32'(i0_r) < 32'(VERTEX_DEPTH);
  assign tri_ok  = i0_ok && (32'(i1_r) < 32'(VERTEX_DEPTH)) && (32'(i2_r) < 32'(VERTEX_DEPTH));

  // Vertex store: one write port for loads, registered reads into the corner registers.
  always_ff @(posedge clk) begin
    if (cmd.load_wr && i0_ok) begin
      vmem[addr] <= vtx_r;
    end
    if (cmd.vert_rd) begin
      case (cmd.corner)
        2'd0:    pa_r <= vmem[addr];
        2'd1:    pb_r <= vmem[addr];
        default: pc_r <= vmem[addr];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    du1_r    <= UW'(pb_r.u) - UW'(pa_r.u);
    dv1_r    <= UW'(pb_r.v) - UW'(pa_r.v);
    du2_r    <= UW'(pc_r.u) - UW'(pa_r.u);
    dv2_r    <= UW'(pc_r.v) - UW'(pa_r.v);
    e1_r[0]  <= EW'(pb_r.px) - EW'(pa_r.px);
    e1_r[1]  <= EW'(pb_r.py) - EW'(pa_r.py);
    e1_r[2]  <= EW'(pb_r.pz) - EW'(pa_r.pz);
    e2_r[0]  <= EW'(pc_r.px) - EW'(pa_r.px);
    e2_r[1]  <= EW'(pc_r.py) - EW'(pa_r.py);
    e2_r[2]  <= EW'(pc_r.pz) - EW'(pa_r.pz);
  end

  // Even steps load a result slot, odd steps subtract from it.
  always_comb begin
    case (cmd.mul_sel)
      4'd0:    begin opa = du1_r; opb = EW'(dv2_r); end
      4'd1:    begin opa = du2_r; opb = EW'(dv1_r); end
      4'd2:    begin opa = dv2_r; opb = e1_r[0]; end
      4'd3:    begin opa = dv1_r; opb = e2_r[0]; end
      4'd4:    begin opa = dv2_r; opb = e1_r[1]; end
      4'd5:    begin opa = dv1_r; opb = e2_r[1]; end
      4'd6:    begin opa = dv2_r; opb = e1_r[2]; end
      4'd7:    begin opa = dv1_r; opb = e2_r[2]; end
      4'd8:    begin opa = du1_r; opb = e2_r[0]; end
      4'd9:    begin opa = du2_r; opb = e1_r[0]; end
      4'd10:   begin opa = du1_r; opb = e2_r[1]; end
      4'd11:   begin opa = du2_r; opb = e1_r[1]; end
      4'd12:   begin opa = du1_r; opb = e2_r[2]; end
      4'd13:   begin opa = du2_r; opb = e1_r[2]; end
      default: begin opa = '0;    opb = '0;      end
    endcase
  end

  assign ridx = msel_d_r[3:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= PW'(opa) * PW'(opb);
    msel_d_r <= cmd.mul_sel;
    if (mv_r) begin
      if (msel_d_r[0]) begin
        res_r[ridx] <= res_r[ridx] - CW'(prod_r);
      end else begin
        res_r[ridx] <= CW'(prod_r);
      end
    end else if (cmd.fix_sign && res_r[0][CW-1]) begin
      for (int i = 1; i < 7; i++) begin
        res_r[i] <= -res_r[i];
      end
    end
  end

  always_comb begin
    case (cmd.norm_sel)
      tta_pkg::NSEL_TRI_T: begin
        for (int i = 0; i < 3; i++) nin[i] = res_r[1 + i];
      end
      tta_pkg::NSEL_TRI_B: begin
        for (int i = 0; i < 3; i++) nin[i] = res_r[4 + i];
      end
      tta_pkg::NSEL_ACC_T: begin
        for (int i = 0; i < 3; i++) begin
          nin[i] = i0_ok ? CW'($signed(acc_q_r[i*ACCUM_WIDTH +: ACCUM_WIDTH])) : '0;
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          nin[i] = i0_ok ? CW'($signed(acc_q_r[(i+3)*ACCUM_WIDTH +: ACCUM_WIDTH])) : '0;
        end
      end
    endcase
  end

  tta_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.norm_start),
    .comp  (nin),
    .res   (nres),
    .done  (ndone)
  );

  always_ff @(posedge clk) begin
    if (cmd.store_t) tn_r <= nres;
    if (cmd.store_b) bn_r <= nres;
  end

  // Saturating add of the unit vectors into one accumulator row.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sat_sum[i] = SW'($signed(acc_q_r[i*ACCUM_WIDTH +: ACCUM_WIDTH]))
                 + SW'((i < 3) ? tn_r[i % 3] : bn_r[i % 3]);
      if (sat_sum[i][SW-1] != sat_sum[i][SW-2]) begin
        sat_row[i*ACCUM_WIDTH +: ACCUM_WIDTH] = sat_sum[i][SW-1] ? ACC_MIN : ACC_MAX;
      end else begin
        sat_row[i*ACCUM_WIDTH +: ACCUM_WIDTH] = sat_sum[i][ACCUM_WIDTH-1:0];
      end
    end
  end

  assign amem_we = (cmd.load_wr && i0_ok) || cmd.acc_wr;
  assign amem_wd = cmd.load_wr ? '0 : sat_row;

  always_ff @(posedge clk) begin
    if (amem_we) begin
      amem[addr] <= amem_wd;
    end
    if (cmd.acc_rd) begin
      acc_q_r <= amem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.vertex_index <= i0_r;
      out_r.tx           <= tn_r[0];
      out_r.ty           <= tn_r[1];
      out_r.tz           <= tn_r[2];
      out_r.bx           <= bn_r[0];
      out_r.by           <= bn_r[1];
      out_r.bz           <= bn_r[2];
    end
  end

  assign sts.tri_ok    = tri_ok;
  assign sts.det_zero  = (res_r[0] == '0);
  assign sts.norm_done = ndone;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

endmodule

>>> rtl/triangle_tangent_accumulator_core.sv
// Per-vertex tangent and bitangent accumulator with fixed-point normalization.
// The in_ch channel carries one command beat: mode 0 loads a vertex (position and
// texture coordinate, 12 fractional bits) and clears its accumulators, mode 1
// processes a triangle of three vertex indices, mode 2 reads one vertex back.
// Mode 3 is dropped. Only mode 2 produces an out_ch beat, holding the index and
// the normalized Q1.14 tangent and bitangent.
// Beats are worked on one at a time; a degenerate or out-of-range triangle stops
// before its normalizations. The two iterative normalizations dominate: each runs
// the shift search until the components fit into 24 bits, squares the components,
// takes 25 square-root steps and divides each component by the length.
// Reset returns the sequencer to idle and empties the result register; the vertex
// and accumulator stores are not cleared and must be loaded before use.
// A finished readout sits in the result register while new beats are accepted;
// if the receiver stalls, the next readout waits at its end until the slot frees.
module triangle_tangent_accumulator_core #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int ACCUM_WIDTH  = 21
) (
  input  logic           clk,
  input  logic           rst_n,
  tta_in_if.sink         in_ch,
  tta_out_if.source      out_ch
);

  tta_pkg::cmd_t      cmd;
  tta_pkg::sts_t      sts;
  tta_pkg::in_item_t  in_item;
  tta_pkg::out_item_t out_item;
  logic               in_ready;
  logic               out_valid;

  // Pack the input beat for the datapath.
  assign in_item.i0     = in_ch.first_index;
  assign in_item.i1     = in_ch.second_index;
  assign in_item.i2     = in_ch.third_index;
  assign in_item.vtx.px = in_ch.pos_x;
  assign in_item.vtx.py = in_ch.pos_y;
  assign in_item.vtx.pz = in_ch.pos_z;
  assign in_item.vtx.u  = in_ch.tex_u;
  assign in_item.vtx.v  = in_ch.tex_v;

  tta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tta_dp #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .ACCUM_WIDTH  (ACCUM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.vertex_index = out_item.vertex_index;
  assign out_ch.tangent_x    = out_item.tx;
  assign out_ch.tangent_y    = out_item.ty;
  assign out_ch.tangent_z    = out_item.tz;
  assign out_ch.bitangent_x  = out_item.bx;
  assign out_ch.bitangent_y  = out_item.by;
  assign out_ch.bitangent_z  = out_item.bz;

endmodule

>>> rtl/tta_checker.sv
`include "triangle_tangent_accumulator_core_assert.svh"

// Port-level checks of the tangent accumulator core.
module tta_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input tta_pkg::mode_t     in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input tta_pkg::idx_t      out_vertex_index,
  input logic signed [15:0] out_tangent_x,
  input logic signed [15:0] out_bitangent_x
);

  `TTA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_vertex_index) && $stable(out_tangent_x))
  `TTA_ASSERT_NOW(a_unit_range, out_valid, (out_tangent_x <= 16'sd16384) && (out_tangent_x >= -16'sd16384) && (out_bitangent_x <= 16'sd16384) && (out_bitangent_x >= -16'sd16384))
  `TTA_ASSERT_NEXT(a_busy_after_work, in_valid && in_ready && ((in_mode == tta_pkg::MODE_TRI) || (in_mode == tta_pkg::MODE_READ)), !in_ready)
  `TTA_ASSERT_NEXT(a_rsvd_dropped, in_valid && in_ready && (in_mode == tta_pkg::MODE_RSVD), in_ready)

endmodule

bind triangle_tangent_accumulator_core tta_checker u_tta_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_mode         (in_ch.mode),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_vertex_index(out_ch.vertex_index),
  .out_tangent_x   (out_ch.tangent_x),
  .out_bitangent_x (out_ch.bitangent_x)
);
